### sv/iecfade_pkg.sv
// Shared types, constants and helpers of the IEC958 subframe encoder with fade-in.
`default_nettype none
package iecfade_pkg;

	// fade ramp length in frames (a power of two, so the gain divide is a shift)
	localparam int unsigned RAMP_FRAMES  = 4096;
	localparam int unsigned FADE_SHIFT   = $clog2(RAMP_FRAMES);
	localparam int unsigned FADE_W       = FADE_SHIFT + 1;
	// frames per channel-status block
	localparam int unsigned BLOCK_FRAMES = 192;
	localparam int unsigned POS_W        = 8;
	localparam int unsigned CH_W         = 3;
	localparam int unsigned MAX_CHANNELS = 8;
	localparam int unsigned SAMPLE_W     = 16;
	localparam int unsigned SUBFRAME_W   = 32;

	// preamble codes in subframe bits 0-3
	localparam logic [3:0] PRE_Z = 4'h8;
	localparam logic [3:0] PRE_X = 4'h2;
	localparam logic [3:0] PRE_Y = 4'h4;

	// channel-status block constants
	localparam logic [7:0] CS_BYTE0 = 8'h0C;
	localparam logic [7:0] CS_BYTE4 = 8'h08;

	// register map, selected by paddr[2]
	typedef enum logic {
		REG_CHANNEL_COUNT = 1'b0,
		REG_RATE_CODE     = 1'b1
	} reg_idx_t;

	// per-item context captured from the frame counters at accept time
	typedef struct packed {
		logic                    chan_nonzero;
		logic [POS_W-1:0]        block_pos;
		logic [FADE_W-1:0]       ramp_pos;
		logic                    last;
	} ctx_t;

	// channel-status bit for a frame within the 192-bit block, LSB first per byte
	function automatic logic status_bit(input logic [POS_W-1:0] pos, input logic [3:0] rate);
		logic [4:0] byte_idx;
		logic [2:0] bit_idx;
		logic [7:0] cs_byte;
		byte_idx = pos[7:3];
		bit_idx  = pos[2:0];
		unique case (byte_idx)
			5'd0:    cs_byte = CS_BYTE0;
			5'd3:    cs_byte = {rate, 4'h0};
			5'd4:    cs_byte = CS_BYTE4;
			default: cs_byte = 8'h00;
		endcase
		return cs_byte[bit_idx];
	endfunction

endpackage
`default_nettype wire

### sv/iecfade_apb_regs.sv
// APB configuration registers: channel count and sample rate code.
`default_nettype none
module iecfade_apb_regs
	import iecfade_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready,
	output logic      [3:0]  channel_count,
	output logic      [3:0]  rate_code
);

	logic     wr_en;
	reg_idx_t sel;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite;
	assign sel    = reg_idx_t'(paddr[2]);

	// register write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			channel_count <= 4'd2;
			rate_code     <= 4'd2;
		end else if (wr_en) begin
			unique case (sel)
				REG_CHANNEL_COUNT: channel_count <= pwdata[3:0];
				REG_RATE_CODE:     rate_code     <= pwdata[3:0];
			endcase
		end
	end

	// read mux
	always_comb begin
		unique case (sel)
			REG_CHANNEL_COUNT: prdata = {28'd0, channel_count};
			REG_RATE_CODE:     prdata = {28'd0, rate_code};
		endcase
	end

endmodule
`default_nettype wire

### sv/iecfade_frame_ctr.sv
// Channel, status-block and fade counters; yields the context of each accepted item.
`default_nettype none
module iecfade_frame_ctr
	import iecfade_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       advance,
	input  wire logic [3:0] channel_count,
	output ctx_t            ctx,
	output logic [POS_W-1:0]  block_pos_q,
	output logic [FADE_W-1:0] ramp_pos_q
);

	logic [CH_W-1:0] chan_q;
	logic [3:0]      count;
	logic [3:0]      chan_next;
	logic            last;

	// clamp channel count into 1..8
	always_comb begin
		priority if (channel_count == 4'd0)
			count = 4'd1;
		else if (channel_count > 4'(MAX_CHANNELS))
			count = 4'(MAX_CHANNELS);
		else
			count = channel_count;
	end

	assign chan_next = {1'b0, chan_q} + 4'd1;
	assign last      = chan_next >= count;

	assign ctx.chan_nonzero = chan_q != '0;
	assign ctx.block_pos    = block_pos_q;
	assign ctx.ramp_pos     = ramp_pos_q;
	assign ctx.last         = last;

	// the channel counter advances once per accepted item; block and fade counters once per frame
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chan_q      <= '0;
			block_pos_q <= '0;
			ramp_pos_q  <= '0;
		end else if (advance) begin
			if (last) begin
				chan_q      <= '0;
				block_pos_q <= (block_pos_q == POS_W'(BLOCK_FRAMES - 1)) ? '0 : block_pos_q + 1'b1;
				if (ramp_pos_q != FADE_W'(RAMP_FRAMES))
					ramp_pos_q <= ramp_pos_q + 1'b1;
			end else begin
				chan_q <= chan_next[CH_W-1:0];
			end
		end
	end

endmodule
`default_nettype wire

### sv/iecfade_encode.sv
// Fade gain and IEC958 subframe assembly for one sample.
`default_nettype none
module iecfade_encode
	import iecfade_pkg::*;
(
	input  wire logic signed [SAMPLE_W-1:0] sample,
	input  wire ctx_t                       ctx,
	input  wire logic [3:0]                 rate_code,
	output logic signed [SAMPLE_W-1:0]      faded_sample,
	output logic [SUBFRAME_W-1:0]           subframe
);

	localparam int unsigned PROD_W = SAMPLE_W + FADE_W + 1;

	logic signed [PROD_W-1:0] prod;
	logic signed [PROD_W-1:0] biased;
	logic                     cs_bit;
	logic                     parity;
	logic [3:0]               preamble;

	// gain: sample * ramp_pos / RAMP_FRAMES, truncated toward zero
	assign prod   = PROD_W'(sample) * PROD_W'(signed'({1'b0, ctx.ramp_pos}));
	assign biased = prod[PROD_W-1] ? prod + PROD_W'(RAMP_FRAMES - 1) : prod;

	always_comb begin
		if (ctx.ramp_pos == FADE_W'(RAMP_FRAMES))
			faded_sample = sample;
		else
			faded_sample = biased[FADE_SHIFT +: SAMPLE_W];
	end

	assign cs_bit = status_bit(ctx.block_pos, rate_code);
	// even parity over bits 4-30: only audio and status bits can be set there
	assign parity = ^{faded_sample, cs_bit};

	always_comb begin
		priority if (ctx.chan_nonzero)
			preamble = PRE_Y;
		else if (ctx.block_pos == '0)
			preamble = PRE_Z;
		else
			preamble = PRE_X;
	end

	assign subframe = {parity, cs_bit, 2'b00, faded_sample, 8'h00, preamble};

endmodule
`default_nettype wire

### sv/iec958_subframe_encoder_with_fade_core.sv
// Top level of the IEC958 subframe encoder with linear fade-in.
// Takes one signed 16-bit PCM sample per item, channels interleaved, and returns the
// faded sample, the 32-bit IEC958 subframe and a frame-end flag (tlast). The block
// accepts one item every clock cycle unless m_tready low holds a full result register; the
// input register holds the sample with its frame context, and a single pass through
// the 16x14 gain multiplier, parity tree and packing feeds the result register,
// which drives the output. During the first 4096 frames after reset the
// sample is scaled by frame/4096, truncated toward zero. Registers: channel_count at
// 0x0 (0 acts as 1, above 8 acts as 8), rate_code at 0x4 (upper nibble of status
// byte 3). Write them only while the stream is idle.
`default_nettype none
module iec958_subframe_encoder_with_fade_core
	import iecfade_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	// APB configuration
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready,
	// sample input
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [15:0] s_tdata,   // [15:0] sample
	// result output
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [47:0]      m_tdata,   // [15:0] faded_sample, [47:16] subframe
	output logic             m_tlast    // frame_end
);

	logic [3:0]  channel_count;
	logic [3:0]  rate_code;
	logic        accept;
	logic        adv2;
	ctx_t        ctx;
	logic [POS_W-1:0]  block_pos_q;
	logic [FADE_W-1:0] ramp_pos_q;

	logic                       valid_s1;
	logic signed [SAMPLE_W-1:0] sample_s1;
	ctx_t                       ctx_s1;

	logic signed [SAMPLE_W-1:0] faded;
	logic [SUBFRAME_W-1:0]      subframe;

	logic                       valid_s2;
	logic signed [SAMPLE_W-1:0] faded_s2;
	logic [SUBFRAME_W-1:0]      subframe_s2;
	logic                       last_s2;

	iecfade_apb_regs u_regs (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready),
		.channel_count (channel_count),
		.rate_code     (rate_code)
	);

	// handshake: result register frees when empty or taken
	assign adv2     = !valid_s2 || m_tready;
	assign s_tready = !valid_s1 || adv2;
	assign accept   = s_tvalid && s_tready;

	iecfade_frame_ctr u_ctr (
		.clk           (clk),
		.arst_n        (arst_n),
		.advance       (accept),
		.channel_count (channel_count),
		.ctx           (ctx),
		.block_pos_q   (block_pos_q),
		.ramp_pos_q    (ramp_pos_q)
	);

	// input register: valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (adv2) begin
			valid_s1 <= 1'b0;
		end
	end

	// input register: payload
	always_ff @(posedge clk) begin
		if (accept) begin
			sample_s1 <= signed'(s_tdata[SAMPLE_W-1:0]);
			ctx_s1    <= ctx;
		end
	end

	iecfade_encode u_enc (
		.sample       (sample_s1),
		.ctx          (ctx_s1),
		.rate_code    (rate_code),
		.faded_sample (faded),
		.subframe     (subframe)
	);

	// result register: valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv2) begin
			valid_s2 <= valid_s1;
		end
	end

	// result register: payload
	always_ff @(posedge clk) begin
		if (adv2 && valid_s1) begin
			faded_s2    <= faded;
			subframe_s2 <= subframe;
			last_s2     <= ctx_s1.last;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {subframe_s2, faded_s2};
	assign m_tlast  = last_s2;

	// fade counter saturates at the ramp length
	a_fade_bound: assert property (@(posedge clk) disable iff (!arst_n)
		ramp_pos_q <= FADE_W'(RAMP_FRAMES))
		else $error("fade position beyond ramp length");

	// status block position stays inside the block
	a_block_bound: assert property (@(posedge clk) disable iff (!arst_n)
		block_pos_q < POS_W'(BLOCK_FRAMES))
		else $error("block position out of range");

	// every delivered subframe has even parity over bits 4-31
	a_parity: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (^m_tdata[47:20]) == 1'b0)
		else $error("subframe parity wrong");

	// a delivered preamble is always one of Z, X or Y
	a_preamble: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[19:16] == PRE_Z || m_tdata[19:16] == PRE_X
			|| m_tdata[19:16] == PRE_Y))
		else $error("bad preamble code");

endmodule
`default_nettype wire
